>>> rtl/c2s_pkg.sv
// Cartesian-to-spherical package: payload structs, fixed-point widths,
// CORDIC angle constants and arctangent table. No dependencies.
package c2s_pkg;

  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int FRAC_W  = 32 - COORD_W;
  localparam int ANG_SH  = 32 - ANGLE_W;
  localparam int CDW     = 36;  // CORDIC datapath width
  localparam int CAW     = 36;  // CORDIC angle accumulator width

  localparam logic signed [CAW-1:0] PI_U      = CAW'(64'sh0000_0000_8000_0000);
  localparam logic signed [CAW-1:0] HALF_PI_U = CAW'(64'sh0000_0000_4000_0000);
  localparam logic signed [CAW-1:0] ROUND_U   = CAW'(64'sd1 <<< (ANG_SH - 1));

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } req_t;

  typedef struct packed {
    logic        [COORD_W-1:0] radius;
    logic        [ANGLE_W-1:0] polar_angle;
    logic signed [ANGLE_W-1:0] azimuth;
    logic                      zero_radius;
  } res_t;

  // atan(2^-i), 2^31 per pi, truncated
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/c2s_delay.sv
// Fixed-depth alignment shift line for pipeline side data.
// Depends on nothing.
module c2s_delay #(
  parameter int DEPTH = 1,
  parameter int W     = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (DEPTH == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_line
    logic [W-1:0] tap_q [DEPTH];
    always_ff @(posedge clk_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
    assign q_o = tap_q[DEPTH-1];
  end

endmodule

>>> rtl/c2s_sqrt_pipe.sv
// Pipelined restoring integer square root, one result bit per stage.
// Gives floor root and remainder; carries valid and side data. No package use.
module c2s_sqrt_pipe #(
  parameter int IN_W = 32,
  parameter int SW   = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   val_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [IN_W-1:0]   rem_o,
  output logic [SW-1:0]     side_o
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SW-1:0]   side_q [RW];
  logic [RW-1:0]   valid_q;

  for (genvar g = 0; g < RW; g++) begin : g_stg
    localparam int B = RW - 1 - g;
    logic [IN_W-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic            valid_in;
    logic [IN_W:0]   trial;
    logic [IN_W:0]   rem_x;
    logic [IN_W-1:0] rem_d;
    logic [RW-1:0]   root_d;

    if (g == 0) begin : g_first
      assign rem_in   = val_i;
      assign root_in  = '0;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[g-1];
      assign root_in  = root_q[g-1];
      assign side_in  = side_q[g-1];
      assign valid_in = valid_q[g-1];
    end

    always_comb begin
      trial = ((IN_W+1)'(root_in) << (B + 1)) | ((IN_W+1)'(1) << (2 * B));
      rem_x = {1'b0, rem_in};
      if (rem_x >= trial) begin
        rem_d  = IN_W'(rem_x - trial);
        root_d = root_in | (RW'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      side_q[g] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= valid_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign rem_o   = rem_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

>>> rtl/c2s_cordic_pipe.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, accumulating angle.
// Depends on c2s_pkg for the arctangent table.
module c2s_cordic_pipe
  import c2s_pkg::*;
#(
  parameter int STAGES = 16,
  parameter int DW     = 36,
  parameter int AW     = 36,
  parameter int SW     = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [AW-1:0] ang_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [AW-1:0] ang_o,
  output logic [SW-1:0]        side_o
);

  logic signed [DW-1:0] x_q   [STAGES];
  logic signed [DW-1:0] y_q   [STAGES];
  logic signed [AW-1:0] ang_q [STAGES];
  logic [SW-1:0]        side_q[STAGES];
  logic [STAGES-1:0]    valid_q;

  for (genvar g = 0; g < STAGES; g++) begin : g_stg
    localparam logic [31:0] ATAN = atan_lut(5'(g));
    logic signed [AW-1:0] step;
    logic signed [DW-1:0] x_in, y_in, dx, dy;
    logic signed [AW-1:0] ang_in;
    logic [SW-1:0]        side_in;
    logic                 valid_in;

    if (g == 0) begin : g_first
      assign x_in     = x_i;
      assign y_in     = y_i;
      assign ang_in   = ang_i;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign x_in     = x_q[g-1];
      assign y_in     = y_q[g-1];
      assign ang_in   = ang_q[g-1];
      assign side_in  = side_q[g-1];
      assign valid_in = valid_q[g-1];
    end

    assign step = AW'(ATAN);
    assign dx   = y_in >>> g;
    assign dy   = x_in >>> g;

    always_ff @(posedge clk_i) begin
      if (!y_in[DW-1]) begin
        x_q[g]   <= x_in + dx;
        y_q[g]   <= y_in - dy;
        ang_q[g] <= ang_in + step;
      end else begin
        x_q[g]   <= x_in - dx;
        y_q[g]   <= y_in + dy;
        ang_q[g] <= ang_in - step;
      end
      side_q[g] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= valid_in;
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign ang_o   = ang_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

>>> rtl/cartesian_to_spherical.sv
// Cartesian-to-spherical converter top level: squares, square-root and
// CORDIC pipelines. Depends on c2s_pkg, c2s_delay, c2s_sqrt_pipe, c2s_cordic_pipe.
//
// Usage:
//   A request (x, y, z) is taken on req_i at each rising edge where start is
//   high and busy is low. busy is always low: one request per cycle.
//   Each result appears on res_o for exactly one cycle with done_o high,
//   in request order; the receiver must take it then.
// The result path runs through the input registers, the 32-stage square
//   root of the scaled xy length, the polar-angle CORDIC and the output
//   register.
// Throughput: one request per clock, every stage is a register slice.
// Reset clears all valid bits; no result is produced from data in flight.
// The zero vector gives radius 0, both angles 0 and zero_radius set.
// Azimuth and polar angle use 2^(ANGLE_W-1) for pi.
module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  localparam int SQ_W    = 2 * COORD_W;
  localparam int RHO_W   = 2 * (COORD_W + FRAC_W);
  localparam int RHO_STG = RHO_W / 2;
  localparam int RAD_STG = SQ_W / 2;
  localparam int SIDE1_W = 2 + COORD_W;
  localparam int SIDE2_W = 3 + ANGLE_W + COORD_W;

  logic v0_q, v1_q, v2_q;
  req_t p0_q, p1_q, p2_q;
  logic [COORD_W-1:0] ax, ay, az;
  logic [SQ_W-1:0] sqx_q, sqy_q, sqz_q, sum_s_q, rhosq_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  assign ax = p0_q.x_coord[COORD_W-1] ? COORD_W'(-p0_q.x_coord) : p0_q.x_coord;
  assign ay = p0_q.y_coord[COORD_W-1] ? COORD_W'(-p0_q.y_coord) : p0_q.y_coord;
  assign az = p0_q.z_coord[COORD_W-1] ? COORD_W'(-p0_q.z_coord) : p0_q.z_coord;

  always_ff @(posedge clk_i) begin
    p0_q    <= req_i;
    p1_q    <= p0_q;
    p2_q    <= p1_q;
    sqx_q   <= SQ_W'(ax) * SQ_W'(ax);
    sqy_q   <= SQ_W'(ay) * SQ_W'(ay);
    sqz_q   <= SQ_W'(az) * SQ_W'(az);
    sum_s_q <= SQ_W'({2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q});
    rhosq_q <= SQ_W'({1'b0, sqx_q} + {1'b0, sqy_q});
  end

  // stage-2 flags
  logic zero2, onz2;
  assign onz2  = (p2_q.x_coord == '0) && (p2_q.y_coord == '0);
  assign zero2 = onz2 && (p2_q.z_coord == '0);

  // rho = floor(sqrt(xs^2 + ys^2))
  logic                   rho_v;
  logic [RHO_W/2-1:0]     rho_root;
  logic [SIDE1_W-1:0]     rho_side;
  c2s_sqrt_pipe #(.IN_W(RHO_W), .SW(SIDE1_W)) u_rho (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .val_i  ({rhosq_q, (2*FRAC_W)'(0)}),
    .side_i ({zero2, onz2, p2_q.z_coord}),
    .valid_o(rho_v),
    .root_o (rho_root),
    .rem_o  (),
    .side_o (rho_side)
  );

  // radius, rounded
  logic [RAD_STG-1:0] rad_root;
  logic [SQ_W-1:0]    rad_rem;
  logic [COORD_W-1:0] rad_rnd, rad_al;
  c2s_sqrt_pipe #(.IN_W(SQ_W), .SW(1)) u_rad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .val_i  (sum_s_q),
    .side_i (1'b0),
    .valid_o(),
    .root_o (rad_root),
    .rem_o  (rad_rem),
    .side_o ()
  );
  assign rad_rnd = (rad_rem > SQ_W'(rad_root)) ? COORD_W'(rad_root + 1'b1)
                                               : COORD_W'(rad_root);
  c2s_delay #(.DEPTH(RHO_STG - RAD_STG), .W(COORD_W)) u_rad_dly (
    .clk_i(clk_i), .d_i(rad_rnd), .q_o(rad_al)
  );

  // azimuth
  logic signed [CDW-1:0] xs2, ys2, phx, phy;
  logic signed [CAW-1:0] pha, phi_ang, phi_sum;
  logic [ANGLE_W-1:0]    phi_out, phi_al;
  assign xs2 = CDW'(p2_q.x_coord) <<< FRAC_W;
  assign ys2 = CDW'(p2_q.y_coord) <<< FRAC_W;
  always_comb begin
    if (p2_q.x_coord[COORD_W-1]) begin
      if (!p2_q.y_coord[COORD_W-1]) begin
        phx = ys2;
        phy = -xs2;
        pha = HALF_PI_U;
      end else begin
        phx = -ys2;
        phy = xs2;
        pha = -HALF_PI_U;
      end
    end else begin
      phx = xs2;
      phy = ys2;
      pha = '0;
    end
  end
  c2s_cordic_pipe #(.STAGES(CORDIC_STAGES), .DW(CDW), .AW(CAW), .SW(1)) u_phi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .x_i    (phx),
    .y_i    (phy),
    .ang_i  (pha),
    .side_i (1'b0),
    .valid_o(),
    .ang_o  (phi_ang),
    .side_o ()
  );
  assign phi_sum = (phi_ang + ROUND_U) >>> ANG_SH;
  assign phi_out = phi_sum[ANGLE_W-1:0];
  c2s_delay #(.DEPTH(RHO_STG - CORDIC_STAGES), .W(ANGLE_W)) u_phi_dly (
    .clk_i(clk_i), .d_i(phi_out), .q_o(phi_al)
  );

  // polar angle
  logic signed [COORD_W-1:0] z3;
  logic                      zero3, onz3, zneg3;
  logic signed [CDW-1:0]     zs3, rho3, thx, thy;
  logic signed [CAW-1:0]     tha;
  assign {zero3, onz3, z3} = rho_side;
  assign zneg3 = z3[COORD_W-1];
  assign zs3   = CDW'(z3) <<< FRAC_W;
  assign rho3  = CDW'({1'b0, rho_root});
  always_comb begin
    if (zneg3) begin
      thx = rho3;
      thy = -zs3;
      tha = HALF_PI_U;
    end else begin
      thx = zs3;
      thy = rho3;
      tha = '0;
    end
  end

  logic                  th_v;
  logic signed [CAW-1:0] th_ang, th_cl, th_sum;
  logic [SIDE2_W-1:0]    th_side;
  logic                  zero4, onz4, zneg4;
  logic [ANGLE_W-1:0]    phi4;
  logic [COORD_W-1:0]    rad4;
  c2s_cordic_pipe #(.STAGES(CORDIC_STAGES), .DW(CDW), .AW(CAW), .SW(SIDE2_W)) u_theta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(rho_v),
    .x_i    (thx),
    .y_i    (thy),
    .ang_i  (tha),
    .side_i ({zero3, onz3, zneg3, phi_al, rad_al}),
    .valid_o(th_v),
    .ang_o  (th_ang),
    .side_o (th_side)
  );
  assign {zero4, onz4, zneg4, phi4, rad4} = th_side;

  always_comb begin
    if (th_ang[CAW-1]) begin
      th_cl = '0;
    end else if (th_ang > PI_U) begin
      th_cl = PI_U;
    end else begin
      th_cl = th_ang;
    end
    th_sum = (th_cl + ROUND_U) >>> ANG_SH;
  end

  res_t res_d, res_q;
  logic done_q;
  always_comb begin
    res_d.radius      = rad4;
    res_d.zero_radius = zero4;
    if (zero4) begin
      res_d.polar_angle = '0;
      res_d.azimuth     = '0;
    end else if (onz4) begin
      res_d.polar_angle = zneg4 ? (ANGLE_W'(1) << (ANGLE_W - 1)) : '0;
      res_d.azimuth     = '0;
    end else begin
      res_d.polar_angle = th_sum[ANGLE_W-1:0];
      res_d.azimuth     = phi4;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= th_v;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
